[src/imu_bias_calibrator_assert.svh]
// assertion helpers for the imu bias calibrator
`ifndef IMU_BIAS_CALIBRATOR_ASSERT_SVH
`define IMU_BIAS_CALIBRATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IBC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ibc_pkg.sv]
package ibc_pkg;

  // sample layout: lanes 0..2 gyro x/y/z, lanes 3..5 accel x/y/z
  localparam int AXES      = 6;
  localparam int ACC_BASE  = 3;
  localparam int ACC_AXES  = 3;
  localparam int RAW_W     = 16;
  localparam int OFS_W     = 17;
  localparam int THR_W     = 16;
  localparam int RUN_W     = 8;
  localparam int GRAV_W    = 15;
  localparam int AVG_COUNT = 100;

  // remainder and average counter width
  localparam int RW = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
  localparam logic [RW-1:0] AVG_LAST = RW'(AVG_COUNT - 1);

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(400);
  localparam logic [RUN_W-1:0]  RUN_RESET  = RUN_W'(100);
  localparam logic [GRAV_W-1:0] GRAV_RESET = GRAV_W'(16384);

  typedef enum logic [1:0] {
    PH_RUN  = 2'd0,
    PH_WAIT = 2'd1,
    PH_AVG  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_RUN_LENGTH = 2'd1,
    REG_GRAVITY    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                        command;
    logic [AXES-1:0][RAW_W-1:0]  axis;
  } sample_t;

  typedef struct packed {
    logic [AXES-1:0][RAW_W-1:0]  axis;
    phase_t                      phase;
    logic                        offsets_updated;
  } result_t;

  typedef struct packed {
    logic [THR_W-1:0]  still_threshold;
    logic [RUN_W-1:0]  still_run_length;
    logic [GRAV_W-1:0] gravity_counts;
  } cfg_t;

  typedef struct packed {
    phase_t          phase;
    logic [RW-1:0]   avg_cnt;
  } status_t;

endpackage

[src/ibc_cfg_regs.sv]
module ibc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ibc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ibc_pkg::DATA_W-1:0]  pwdata,
  output logic [ibc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ibc_pkg::cfg_t               cfg
);
  import ibc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD:  cfg_nxt.still_threshold  = pwdata[THR_W-1:0];
        REG_RUN_LENGTH: cfg_nxt.still_run_length = pwdata[RUN_W-1:0];
        REG_GRAVITY:    cfg_nxt.gravity_counts   = pwdata[GRAV_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.still_threshold  <= THR_RESET;
      cfg_r.still_run_length <= RUN_RESET;
      cfg_r.gravity_counts   <= GRAV_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read mux
  always_comb begin
    unique case (idx)
      REG_THRESHOLD:  prdata = DATA_W'(cfg_r.still_threshold);
      REG_RUN_LENGTH: prdata = DATA_W'(cfg_r.still_run_length);
      REG_GRAVITY:    prdata = DATA_W'(cfg_r.gravity_counts);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[src/ibc_in_stage.sv]
module ibc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ibc_pkg::sample_t  in_sample,
  input  logic              advance,
  output logic              s1_valid,
  output ibc_pkg::sample_t  s1_sample
);
  import ibc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  sample_t sample_r;
  logic    accept;

  // hold off only when this stage is full and cannot move on
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
    end
  end

  assign s1_valid  = valid_r;
  assign s1_sample = sample_r;

endmodule

[src/ibc_core.sv]
module ibc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  ibc_pkg::cfg_t     cfg,
  input  logic              s1_valid,
  input  ibc_pkg::sample_t  s1_sample,
  input  logic              advance,
  output ibc_pkg::result_t  result,
  output ibc_pkg::status_t  status
);
  import ibc_pkg::*;

  // running sum kept as quotient and floor remainder by AVG_COUNT
  localparam int Q_W   = 24;
  localparam int T_W   = 18;
  localparam int U_W   = 17;
  localparam int SH    = U_W + RW;
  localparam int M_W   = SH + 1;
  localparam int P_W   = U_W + M_W;
  localparam int BIAS_K = (65536 + AVG_COUNT - 1) / AVG_COUNT;
  localparam logic [T_W-1:0] BIAS = T_W'(AVG_COUNT * BIAS_K);
  localparam logic [M_W-1:0] RECIP =
    M_W'(((longint'(1) << SH) + longint'(AVG_COUNT) - 1) / longint'(AVG_COUNT));

  phase_t                              phase_r, phase_nxt;
  logic [RUN_W-1:0]                    still_cnt_r, still_cnt_nxt;
  logic [RW-1:0]                       avg_cnt_r, avg_cnt_nxt;
  logic [AXES-1:0][OFS_W-1:0]          ofs_r, ofs_nxt;
  logic [ACC_AXES-1:0][RAW_W-1:0]      prev_r, prev_nxt;
  logic [AXES-1:0][Q_W-1:0]            q_r, q_nxt;
  logic [AXES-1:0][RW-1:0]             rem_r, rem_nxt;

  logic                                fire;
  logic                                updated;
  logic                                all_still;
  logic [RUN_W-1:0]                    still_inc;
  logic [AXES-1:0][RAW_W-1:0]          corr;
  logic [AXES-1:0][T_W-1:0]            term;
  logic [AXES-1:0][U_W-1:0]            u_val;
  logic [AXES-1:0][P_W-1:0]            prod;
  logic [AXES-1:0][U_W-1:0]            q_lane;
  logic [AXES-1:0][U_W-1:0]            rem_full;
  logic [AXES-1:0][RW-1:0]             rem_lane;
  logic [AXES-1:0][Q_W-1:0]            q_sum;
  logic [AXES-1:0][Q_W-1:0]            q_trunc;
  logic [ACC_AXES-1:0][RAW_W:0]        diff;
  logic [ACC_AXES-1:0][RAW_W:0]        diff_abs;
  logic [ACC_AXES-1:0]                 still_ax;

  assign fire = s1_valid && advance;

  // per-lane correction and sum step (floor division by reciprocal)
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      corr[i] = s1_sample.axis[i] - ofs_r[i][RAW_W-1:0];
      term[i] = {{(T_W-RAW_W){corr[i][RAW_W-1]}}, corr[i]};
      if (i == AXES - 1) begin
        term[i] = term[i] - T_W'(cfg.gravity_counts);
      end
      term[i]     = term[i] + T_W'(rem_r[i]) + BIAS;
      u_val[i]    = term[i][U_W-1:0];
      prod[i]     = P_W'(u_val[i]) * P_W'(RECIP);
      q_lane[i]   = prod[i][SH +: U_W];
      rem_full[i] = u_val[i] - U_W'(q_lane[i] * U_W'(AVG_COUNT));
      rem_lane[i] = rem_full[i][RW-1:0];
      q_sum[i]    = q_r[i] + Q_W'(q_lane[i]) - Q_W'(BIAS_K);
      // truncate toward zero: negative with a remainder rounds up
      q_trunc[i]  = q_sum[i] + Q_W'(q_sum[i][Q_W-1] && (rem_lane[i] != '0));
    end
  end

  // stillness test on corrected accel, full precision difference
  always_comb begin
    for (int j = 0; j < ACC_AXES; j++) begin
      diff[j] = {corr[ACC_BASE+j][RAW_W-1], corr[ACC_BASE+j]}
              - {prev_r[j][RAW_W-1], prev_r[j]};
      diff_abs[j] = diff[j][RAW_W] ? (~diff[j] + 1'b1) : diff[j];
      still_ax[j] = diff_abs[j] < {1'b0, cfg.still_threshold};
    end
  end

  assign all_still = &still_ax;
  assign still_inc = all_still ? (still_cnt_r + 1'b1) : '0;

  // calibration sequencer
  always_comb begin
    phase_nxt     = phase_r;
    still_cnt_nxt = still_cnt_r;
    avg_cnt_nxt   = avg_cnt_r;
    ofs_nxt       = ofs_r;
    prev_nxt      = prev_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    updated       = 1'b0;
    if (s1_sample.command) begin
      phase_nxt     = PH_WAIT;
      still_cnt_nxt = '0;
      for (int j = 0; j < ACC_AXES; j++) begin
        prev_nxt[j] = corr[ACC_BASE+j];
      end
    end else begin
      unique case (phase_r)
        PH_WAIT: begin
          for (int j = 0; j < ACC_AXES; j++) begin
            prev_nxt[j] = corr[ACC_BASE+j];
          end
          still_cnt_nxt = still_inc;
          if (still_inc >= cfg.still_run_length) begin
            phase_nxt   = PH_AVG;
            avg_cnt_nxt = '0;
            q_nxt       = '0;
            rem_nxt     = '0;
          end
        end
        PH_AVG: begin
          for (int i = 0; i < AXES; i++) begin
            q_nxt[i]   = q_sum[i];
            rem_nxt[i] = rem_lane[i];
          end
          if (avg_cnt_r == AVG_LAST) begin
            for (int i = 0; i < AXES; i++) begin
              ofs_nxt[i] = q_trunc[i][OFS_W-1:0];
            end
            avg_cnt_nxt = '0;
            phase_nxt   = PH_RUN;
            updated     = 1'b1;
          end else begin
            avg_cnt_nxt = avg_cnt_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RUN;
      still_cnt_r <= '0;
      avg_cnt_r   <= '0;
      ofs_r       <= '0;
      prev_r      <= '0;
      q_r         <= '0;
      rem_r       <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      still_cnt_r <= still_cnt_nxt;
      avg_cnt_r   <= avg_cnt_nxt;
      ofs_r       <= ofs_nxt;
      prev_r      <= prev_nxt;
      q_r         <= q_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // result carries corrected sample, phase after this step
  assign result.axis            = corr;
  assign result.phase           = phase_nxt;
  assign result.offsets_updated = updated;

  assign status.phase   = phase_r;
  assign status.avg_cnt = avg_cnt_r;

endmodule

[src/ibc_out_stage.sv]
module ibc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  ibc_pkg::result_t  result,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output ibc_pkg::result_t  out_result
);
  import ibc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // the result register frees up when empty or when taken
  assign advance   = !valid_r || !out_stall;
  assign valid_nxt = advance ? s1_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

[src/imu_bias_calibrator.sv]
// imu bias calibrator: subtracts per-axis offsets from six-axis samples
// path: an accepted request is held in the input register, then in the result register
// throughput: one request per cycle while out_stall is low; the input and result registers advance together
// the offset and calibration state loop closes through the core registers, updated once per sample
// reset: offsets, sums and counters clear, phase is running, registers take defaults
`include "imu_bias_calibrator_assert.svh"

module imu_bias_calibrator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic signed [15:0]          in_gyro_x_raw,
  input  logic signed [15:0]          in_gyro_y_raw,
  input  logic signed [15:0]          in_gyro_z_raw,
  input  logic signed [15:0]          in_accel_x_raw,
  input  logic signed [15:0]          in_accel_y_raw,
  input  logic signed [15:0]          in_accel_z_raw,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_gyro_x_out,
  output logic signed [15:0]          out_gyro_y_out,
  output logic signed [15:0]          out_gyro_z_out,
  output logic signed [15:0]          out_accel_x_out,
  output logic signed [15:0]          out_accel_y_out,
  output logic signed [15:0]          out_accel_z_out,
  output logic [1:0]                  out_phase,
  output logic                        out_offsets_updated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ibc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ibc_pkg::DATA_W-1:0]  pwdata,
  output logic [ibc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ibc_pkg::*;

  cfg_t    cfg;
  sample_t in_sample;
  sample_t s1_sample;
  result_t result;
  result_t out_result;
  status_t status;
  logic    s1_valid;
  logic    advance;

  // pack sample ports
  assign in_sample.command = in_command;
  assign in_sample.axis[0] = in_gyro_x_raw;
  assign in_sample.axis[1] = in_gyro_y_raw;
  assign in_sample.axis[2] = in_gyro_z_raw;
  assign in_sample.axis[3] = in_accel_x_raw;
  assign in_sample.axis[4] = in_accel_y_raw;
  assign in_sample.axis[5] = in_accel_z_raw;

  ibc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ibc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample)
  );

  ibc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample),
    .advance   (advance),
    .result    (result),
    .status    (status)
  );

  ibc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  // unpack result ports
  assign out_gyro_x_out      = out_result.axis[0];
  assign out_gyro_y_out      = out_result.axis[1];
  assign out_gyro_z_out      = out_result.axis[2];
  assign out_accel_x_out     = out_result.axis[3];
  assign out_accel_y_out     = out_result.axis[4];
  assign out_accel_z_out     = out_result.axis[5];
  assign out_phase           = out_result.phase;
  assign out_offsets_updated = out_result.offsets_updated;

  // checks
  `IBC_ASSERT_IMPLY(a_upd_running, out_valid && out_offsets_updated, out_phase == PH_RUN, "offset update without return to running")
  `IBC_ASSERT_IMPLY(a_stall_full, in_stall, out_valid && out_stall, "input held off while result side is free")
  `IBC_ASSERT_IMPLY(a_avg_cnt_range, status.phase == PH_AVG, status.avg_cnt <= AVG_LAST, "average counter past its last sample")
  `IBC_ASSERT_NEXT(a_upd_single, out_valid && !out_stall && out_offsets_updated, !(out_valid && out_offsets_updated), "two offset updates in a row")

endmodule
